FILE: rtl/rc5_pkg.sv
// rc5 block cipher shared definitions: constants, datapath commands, rotations
// used by rc5_ctrl, rc5_dpath and rc5_block_cipher; depends on nothing else
package rc5_pkg;

  // cipher geometry
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROUNDS_DEF = 16;
  localparam int unsigned SHIFT_W    = 5;

  // key schedule magic constants
  localparam logic [WORD_W-1:0] MAGIC_P = 32'hC526A3B9;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h2E156A8D;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  // block operation codes
  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  // datapath operation codes
  typedef enum logic [3:0] {
    DP_HOLD,
    DP_INIT_WR,
    DP_MIX_A,
    DP_MIX_B,
    DP_ENC_FIRST_A,
    DP_ENC_FIRST_B,
    DP_ENC_A,
    DP_ENC_B,
    DP_DEC_A,
    DP_DEC_B,
    DP_DEC_LAST_B,
    DP_DEC_LAST_A
  } dp_op_e;

  // controller to datapath command group
  typedef struct packed {
    dp_op_e     dp_op;
    logic       mem_we;
    logic       load_blk;
    logic       clear_exp;
    logic       load_out;
    logic [1:0] word_sel;
  } cmd_t;

  // key register write strobes
  typedef struct packed {
    logic low_we;
    logic high_we;
  } key_wr_t;

  // rotate left, only the low five bits of the amount count
  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [SHIFT_W-1:0] s);
    logic [2*WORD_W-1:0] tmp;
    tmp = {v, v} << s;
    return tmp[2*WORD_W-1:WORD_W];
  endfunction

  // rotate right, only the low five bits of the amount count
  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] v,
                                               input logic [SHIFT_W-1:0] s);
    logic [2*WORD_W-1:0] tmp;
    tmp = {v, v} >> s;
    return tmp[WORD_W-1:0];
  endfunction

endpackage

FILE: rtl/rc5_ctrl.sv
// rc5 controller: sequences table fill, key mixing and the half-round steps
// depends on rc5_pkg; drives rc5_dpath through cmd_t and table addresses
module rc5_ctrl #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF,
  parameter int unsigned IDX_W  = $clog2(2 * ROUNDS + 2)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rc5_pkg::key_wr_t  key_wr_i,
  input  logic              s_valid_i,
  input  logic              s_op_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output rc5_pkg::cmd_t     cmd_o,
  output logic [IDX_W-1:0]  waddr_o,
  output logic [IDX_W-1:0]  raddr_o
);
  import rc5_pkg::*;

  localparam int unsigned TABLE_WORDS = 2 * ROUNDS + 2;
  localparam int unsigned MIX_STEPS   = 3 * TABLE_WORDS;
  localparam int unsigned STEP_W      = $clog2(MIX_STEPS);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TABLE_WORDS - 1);
  localparam logic [IDX_W-1:0]  IDX_ONE   = IDX_W'(1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MIX_STEPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_MIX_A = 3'd2;
  localparam logic [2:0] ST_MIX_B = 3'd3;
  localparam logic [2:0] ST_CRYPT = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        w_q, w_d;
  logic              op_q, op_d;
  logic              ready_q, ready_d;
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  t_next;
  logic [IDX_W-1:0]  crypt_next;
  logic              crypt_last;

  // first table index of a block
  function automatic logic [IDX_W-1:0] first_idx(input logic op);
    return (op == OP_DECRYPT) ? IDX_LAST : '0;
  endfunction

  // next table index in mixing and in the cipher walk
  assign t_next     = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_ONE;
  assign crypt_next = (op_q == OP_DECRYPT) ? idx_q - IDX_ONE : idx_q + IDX_ONE;
  assign crypt_last = (op_q == OP_DECRYPT) ? (idx_q == '0) : (idx_q == IDX_LAST);

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    step_d      = step_q;
    w_d         = w_q;
    op_d        = op_q;
    ready_d     = ready_q;
    out_valid_d = out_valid_q;
    cmd_o          = '0;
    cmd_o.dp_op    = DP_HOLD;
    cmd_o.word_sel = w_q;
    waddr_o     = idx_q;
    raddr_o     = idx_q;

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          op_d           = s_op_i;
          cmd_o.load_blk = 1'b1;
          if (ready_q) begin
            idx_d   = first_idx(s_op_i);
            raddr_o = first_idx(s_op_i);
            state_d = ST_CRYPT;
          end else begin
            cmd_o.clear_exp = 1'b1;
            idx_d           = '0;
            state_d         = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // fill table with the arithmetic progression
        cmd_o.dp_op  = DP_INIT_WR;
        cmd_o.mem_we = 1'b1;
        raddr_o      = '0;
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          step_d  = '0;
          w_d     = '0;
          state_d = ST_MIX_A;
        end else begin
          idx_d = idx_q + IDX_ONE;
        end
      end
      ST_MIX_A: begin
        cmd_o.dp_op = DP_MIX_A;
        state_d     = ST_MIX_B;
      end
      ST_MIX_B: begin
        // write back the subkey, prefetch the next one
        cmd_o.dp_op  = DP_MIX_B;
        cmd_o.mem_we = 1'b1;
        w_d          = w_q + 2'd1;
        if (step_q == STEP_LAST) begin
          ready_d = 1'b1;
          idx_d   = first_idx(op_q);
          raddr_o = first_idx(op_q);
          state_d = ST_CRYPT;
        end else begin
          step_d  = step_q + STEP_W'(1);
          idx_d   = t_next;
          raddr_o = t_next;
          state_d = ST_MIX_A;
        end
      end
      ST_CRYPT: begin
        // one half round per cycle
        if (op_q == OP_DECRYPT) begin
          if (idx_q == '0) begin
            cmd_o.dp_op = DP_DEC_LAST_A;
          end else if (idx_q == IDX_ONE) begin
            cmd_o.dp_op = DP_DEC_LAST_B;
          end else if (idx_q[0]) begin
            cmd_o.dp_op = DP_DEC_B;
          end else begin
            cmd_o.dp_op = DP_DEC_A;
          end
        end else begin
          if (idx_q == '0) begin
            cmd_o.dp_op = DP_ENC_FIRST_A;
          end else if (idx_q == IDX_ONE) begin
            cmd_o.dp_op = DP_ENC_FIRST_B;
          end else if (idx_q[0]) begin
            cmd_o.dp_op = DP_ENC_B;
          end else begin
            cmd_o.dp_op = DP_ENC_A;
          end
        end
        if (crypt_last) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = crypt_next;
          raddr_o = crypt_next;
        end
      end
      ST_DONE: begin
        // move result into the output register once it is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // key write invalidates the expanded table
    if (key_wr_i.low_we || key_wr_i.high_we) begin
      ready_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      w_q         <= '0;
      op_q        <= 1'b0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      w_q         <= w_d;
      op_q        <= op_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/rc5_dpath.sv
// rc5 datapath: key registers, subkey memory, key mixing and half-round unit
// depends on rc5_pkg; commanded by rc5_ctrl
module rc5_dpath #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF,
  parameter int unsigned IDX_W  = $clog2(2 * ROUNDS + 2)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rc5_pkg::key_wr_t                 key_wr_i,
  input  logic [rc5_pkg::CFG_DATA_W-1:0]   key_data_i,
  input  logic [rc5_pkg::WORD_W-1:0]       in_a_i,
  input  logic [rc5_pkg::WORD_W-1:0]       in_b_i,
  input  rc5_pkg::cmd_t                    cmd_i,
  input  logic [IDX_W-1:0]                 waddr_i,
  input  logic [IDX_W-1:0]                 raddr_i,
  output logic [rc5_pkg::WORD_W-1:0]       res_a_o,
  output logic [rc5_pkg::WORD_W-1:0]       res_b_o
);
  import rc5_pkg::*;

  localparam int unsigned TABLE_WORDS = 2 * ROUNDS + 2;

  logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
  logic [WORD_W-1:0]     mem_q [TABLE_WORDS];
  logic [WORD_W-1:0]     rdata_q;
  logic [WORD_W-1:0]     mem_wdata;
  logic [WORD_W-1:0]     l_q [4];
  logic [WORD_W-1:0]     ea_q, ea_d, eb_q, eb_d;
  logic [WORD_W-1:0]     p_acc_q, p_acc_d;
  logic [WORD_W-1:0]     a_q, a_d, b_q, b_d;
  logic [WORD_W-1:0]     res_a_q, res_b_q;
  logic [WORD_W-1:0]     mix_sum_a, mix_sum_b, mix_amt, mix_b;
  logic [WORD_W-1:0]     ab_x;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else begin
      if (key_wr_i.low_we) begin
        key_low_q <= key_data_i;
      end
      if (key_wr_i.high_we) begin
        key_high_q <= key_data_i;
      end
    end
  end

  // subkey memory, registered read, a write to the read address passes through
  assign mem_wdata = (cmd_i.dp_op == DP_MIX_B) ? ea_q : p_acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[waddr_i] <= mem_wdata;
    end
    if (cmd_i.mem_we && (waddr_i == raddr_i)) begin
      rdata_q <= mem_wdata;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // key mixing terms
  assign mix_sum_a = rdata_q + ea_q + eb_q;
  assign mix_amt   = ea_q + eb_q;
  assign mix_sum_b = l_q[cmd_i.word_sel] + mix_amt;
  assign mix_b     = rotl32(mix_sum_b, mix_amt[SHIFT_W-1:0]);
  assign ab_x      = a_q ^ b_q;

  // next values of the working words
  always_comb begin
    ea_d    = ea_q;
    eb_d    = eb_q;
    p_acc_d = p_acc_q;
    a_d     = a_q;
    b_d     = b_q;
    unique case (cmd_i.dp_op)
      DP_HOLD:        ;
      DP_INIT_WR:     p_acc_d = p_acc_q + MAGIC_Q;
      DP_MIX_A:       ea_d = rotl32(mix_sum_a, SHIFT_W'(3));
      DP_MIX_B:       eb_d = mix_b;
      DP_ENC_FIRST_A: a_d = a_q + rdata_q;
      DP_ENC_FIRST_B: b_d = b_q + rdata_q;
      DP_ENC_A:       a_d = rotl32(ab_x, b_q[SHIFT_W-1:0]) + rdata_q;
      DP_ENC_B:       b_d = rotl32(ab_x, a_q[SHIFT_W-1:0]) + rdata_q;
      DP_DEC_B:       b_d = rotr32(b_q - rdata_q, a_q[SHIFT_W-1:0]) ^ a_q;
      DP_DEC_A:       a_d = rotr32(a_q - rdata_q, b_q[SHIFT_W-1:0]) ^ b_q;
      DP_DEC_LAST_B:  b_d = b_q - rdata_q;
      DP_DEC_LAST_A:  a_d = a_q - rdata_q;
      default:        ;
    endcase
    if (cmd_i.clear_exp) begin
      ea_d    = '0;
      eb_d    = '0;
      p_acc_d = MAGIC_P;
    end
    if (cmd_i.load_blk) begin
      a_d = in_a_i;
      b_d = in_b_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ea_q    <= ea_d;
    eb_q    <= eb_d;
    p_acc_q <= p_acc_d;
    a_q     <= a_d;
    b_q     <= b_d;
    if (cmd_i.clear_exp) begin
      l_q[0] <= key_low_q[WORD_W-1:0];
      l_q[1] <= key_low_q[2*WORD_W-1:WORD_W];
      l_q[2] <= key_high_q[WORD_W-1:0];
      l_q[3] <= key_high_q[2*WORD_W-1:WORD_W];
    end else if (cmd_i.dp_op == DP_MIX_B) begin
      l_q[cmd_i.word_sel] <= mix_b;
    end
    if (cmd_i.load_out) begin
      res_a_q <= a_q;
      res_b_q <= b_q;
    end
  end

  assign res_a_o = res_a_q;
  assign res_b_o = res_b_q;

endmodule

FILE: rtl/rc5_block_cipher.sv
// rc5 block cipher top level: stream ports, key register decode
// depends on rc5_pkg, rc5_ctrl and rc5_dpath
//
//   channel   direction  signals                            use
//   s_axis    in         tvalid tready tdata[63:0] tuser[0] block request
//   m_axis    out        tvalid tready tdata[63:0]          result request
//   cfg       in         we idx[0] wdata[63:0]              key registers
//
// a block goes from accept through the crypt and done states to the result:
// one half round per cycle, set by the single read port of the subkey memory
// the first block after reset or a key write first runs the key schedule:
// table fill, then each mixing step in a mix_a and then a mix_b state
// reset clears control and the key registers; the subkey memory holds garbage until expanded
// a finished result waits in the output register; the next block is accepted
// meanwhile and stalls at its end until the output register frees
// ROUNDS ranges from 1 to 32
module rc5_block_cipher #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // word_a [31:0], word_b [63:32]
  input  logic [2*rc5_pkg::WORD_W-1:0]   s_axis_tdata_i,
  // operation [0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // result_a [31:0], result_b [63:32]
  output logic [2*rc5_pkg::WORD_W-1:0]   m_axis_tdata_o,
  input  logic                           cfg_we_i,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rc5_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import rc5_pkg::*;

  localparam int unsigned IDX_W = $clog2(2 * ROUNDS + 2);

  key_wr_t           key_wr;
  cmd_t              cmd;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [WORD_W-1:0] res_a, res_b;

  // key register write decode
  assign key_wr.low_we  = cfg_we_i && (cfg_idx_i == REG_KEY_LOW);
  assign key_wr.high_we = cfg_we_i && (cfg_idx_i == REG_KEY_HIGH);

  rc5_ctrl #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_wr_i  (key_wr),
    .s_valid_i (s_axis_tvalid_i),
    .s_op_i    (s_axis_tuser_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .waddr_o   (waddr),
    .raddr_o   (raddr)
  );

  rc5_dpath #(
    .ROUNDS (ROUNDS),
    .IDX_W  (IDX_W)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_wr_i   (key_wr),
    .key_data_i (cfg_wdata_i),
    .in_a_i     (s_axis_tdata_i[WORD_W-1:0]),
    .in_b_i     (s_axis_tdata_i[2*WORD_W-1:WORD_W]),
    .cmd_i      (cmd),
    .waddr_i    (waddr),
    .raddr_i    (raddr),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  assign m_axis_tdata_o = {res_b, res_a};

endmodule

FILE: bench/rc5_result_check_pkg.sv
// result prediction and checking for the rc5 block cipher bench
// holds the key, the expanded subkey table and the queue of pending results
// depends on rc5_pkg
package rc5_result_check_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import rc5_pkg::*;

  localparam int unsigned NUM_ROUNDS = ROUNDS_DEF;
  localparam int unsigned NUM_SUBKEYS = 2 * NUM_ROUNDS + 2;
  localparam int unsigned NUM_MIX_STEPS = 3 * NUM_SUBKEYS;

  // one 64-bit block as two words
  typedef struct packed {
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] a;
  } word_pair_t;

  class rc5_result_checker;
    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    logic [WORD_W-1:0]     subkeys[NUM_SUBKEYS];
    bit                    subkeys_valid;
    word_pair_t            pending_results[$];
    int                    mismatch_count;

    function new();
      key_low = '0;
      key_high = '0;
      subkeys_valid = 1'b0;
      mismatch_count = 0;
    endfunction

    // rotations, only the low five bits of the amount count
    function logic [WORD_W-1:0] rol(logic [WORD_W-1:0] v, logic [SHIFT_W-1:0] amt);
      if (amt == 0) return v;
      return (v << amt) | (v >> (WORD_W - amt));
    endfunction

    function logic [WORD_W-1:0] ror(logic [WORD_W-1:0] v, logic [SHIFT_W-1:0] amt);
      if (amt == 0) return v;
      return (v >> amt) | (v << (WORD_W - amt));
    endfunction

    // key write, forces a new key schedule before the next block
    function void set_key(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == REG_KEY_LOW) key_low = value;
      else key_high = value;
      subkeys_valid = 1'b0;
    endfunction

    // key schedule: table fill then mixing with the four key words
    function void expand_subkeys();
      logic [WORD_W-1:0] key_words[4];
      logic [WORD_W-1:0] mix_a;
      logic [WORD_W-1:0] mix_b;
      logic [WORD_W-1:0] sum;
      int                t;
      int                w;
      key_words[0] = key_low[31:0];
      key_words[1] = key_low[63:32];
      key_words[2] = key_high[31:0];
      key_words[3] = key_high[63:32];
      subkeys[0] = MAGIC_P;
      for (int n = 1; n < NUM_SUBKEYS; n++) subkeys[n] = subkeys[n-1] + MAGIC_Q;
      mix_a = '0;
      mix_b = '0;
      t = 0;
      w = 0;
      for (int n = 0; n < NUM_MIX_STEPS; n++) begin
        mix_a = rol(subkeys[t] + mix_a + mix_b, SHIFT_W'(3));
        subkeys[t] = mix_a;
        sum = mix_a + mix_b;
        mix_b = rol(key_words[w] + sum, sum[SHIFT_W-1:0]);
        key_words[w] = mix_b;
        t = (t + 1) % NUM_SUBKEYS;
        w = (w + 1) % 4;
      end
      subkeys_valid = 1'b1;
    endfunction

    // encrypt or decrypt one block under the current key
    function word_pair_t cipher_block(op_e op, logic [WORD_W-1:0] a_in,
                                      logic [WORD_W-1:0] b_in);
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      word_pair_t        res;
      if (!subkeys_valid) expand_subkeys();
      a = a_in;
      b = b_in;
      if (op == OP_ENCRYPT) begin
        a = a + subkeys[0];
        b = b + subkeys[1];
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
          a = rol(a ^ b, b[SHIFT_W-1:0]) + subkeys[2*r];
          b = rol(a ^ b, a[SHIFT_W-1:0]) + subkeys[2*r+1];
        end
      end else begin
        for (int r = NUM_ROUNDS; r >= 1; r--) begin
          b = ror(b - subkeys[2*r+1], a[SHIFT_W-1:0]) ^ a;
          a = ror(a - subkeys[2*r], b[SHIFT_W-1:0]) ^ b;
        end
        b = b - subkeys[1];
        a = a - subkeys[0];
      end
      res.a = a;
      res.b = b;
      return res;
    endfunction

    // accepted block request, queue its result
    function void note_request(op_e op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      pending_results.push_back(cipher_block(op, a, b));
    endfunction

    // accepted result request, compare with the oldest pending result
    function void check_result(logic [WORD_W-1:0] res_a, logic [WORD_W-1:0] res_b);
      word_pair_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_a %h result_b %h", res_a, res_b);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (res_a !== want.a) begin
        $error("result_a: expected %h, actual %h", want.a, res_a);
        mismatch_count++;
      end
      if (res_b !== want.b) begin
        $error("result_b: expected %h, actual %h", want.b, res_b);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
// top of the rc5 block cipher bench: clock, reset, stream drivers, key writes
// and the run sequence; depends on rc5_pkg, rc5_result_check_pkg, rc5_block_cipher
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rc5_pkg::*;
  import rc5_result_check_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*WORD_W-1:0]   s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*WORD_W-1:0]   m_axis_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rc5_result_checker result_chk;
  bit                idle_enable;
  int                rx_hold_cycles;

  rc5_block_cipher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run time limit
  initial begin
    #20_000_000;
    $display("rc5_block_cipher: mismatch");
    $finish;
  end

  // result side ready, with random idling and long hold-offs on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_cycles = rx_hold_cycles - 1;
      end else if (idle_enable && $urandom_range(99) < 17) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      result_chk.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32]);
  end

  // word with a bias toward the extremes
  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // one block request, starts and ends at a falling edge
  task automatic send_block(op_e op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    while (idle_enable && $urandom_range(99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    result_chk.note_request(op, a, b);
    @(negedge clk_i);
  endtask

  task automatic sender_quiet();
    s_axis_tvalid = 1'b0;
  endtask

  // wait for every pending result, sender already quiet
  task automatic wait_drained();
    while (result_chk.pending() != 0) @(negedge clk_i);
  endtask

  // key register write, only while the block is idle
  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = value;
    result_chk.set_key(idx, value);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // block and its inverse under the current key
  task automatic send_round_trip(op_e op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    word_pair_t fwd;
    fwd = result_chk.cipher_block(op, a, b);
    send_block(op, a, b);
    send_block(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT, fwd.a, fwd.b);
  endtask

  // random blocks, a quarter of them the inverse of a predicted block
  task automatic send_random(int count);
    op_e        op;
    word_pair_t fwd;
    for (int i = 0; i < count; i++) begin
      op = op_e'($urandom_range(1));
      if ($urandom_range(3) == 0) begin
        fwd = result_chk.cipher_block(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT,
                                      pick_word(), pick_word());
        send_block(op, fwd.a, fwd.b);
      end else begin
        send_block(op, pick_word(), pick_word());
      end
    end
  endtask

  // new key, both registers
  task automatic load_key(logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high);
    write_key(REG_KEY_LOW, low);
    write_key(REG_KEY_HIGH, high);
  endtask

  // run sequence
  initial begin
    result_chk = new();
    idle_enable = 1'b1;
    rx_hold_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ENCRYPT;
    cfg_we = 1'b0;
    cfg_idx = REG_KEY_LOW;
    cfg_wdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed blocks under the all-zero reset key
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    // decrypt rotation amounts of zero in the first round
    send_block(OP_DECRYPT, 32'h1234_5660, 32'hDEAD_BEEF);
    send_block(OP_DECRYPT, 32'hFFFF_FFE0, 32'h0000_0000);
    send_round_trip(OP_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    send_round_trip(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    sender_quiet();
    wait_drained();

    // all-ones key, directed then random
    load_key('1, '1);
    send_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_round_trip(OP_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_random(100);
    sender_quiet();
    wait_drained();

    // low key register alone, long stretch with no idling
    write_key(REG_KEY_LOW, {$urandom, $urandom});
    idle_enable = 1'b0;
    send_random(100);
    sender_quiet();
    wait_drained();
    idle_enable = 1'b1;

    // all-zero key written back; result side holds off and the block fills up
    load_key('0, '0);
    rx_hold_cycles = 400;
    send_random(100);
    sender_quiet();
    wait_drained();

    // random keys, with a full pause of the sender in the middle
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_random(50);
    sender_quiet();
    wait_drained();
    send_random(50);
    sender_quiet();
    wait_drained();

    // high key register alone, then a mixed-extreme key
    write_key(REG_KEY_HIGH, {$urandom, $urandom});
    send_random(100);
    sender_quiet();
    wait_drained();

    load_key(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000);
    rx_hold_cycles = 300;
    send_random(100);
    sender_quiet();
    wait_drained();

    load_key({$urandom, $urandom}, {$urandom, $urandom});
    send_random(50);
    sender_quiet();
    wait_drained();

    repeat (60) @(negedge clk_i);
    if (result_chk.mismatch_count == 0) begin
      $display("rc5_block_cipher: match");
    end else begin
      $display("rc5_block_cipher: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rc5_pkg.sv
rtl/rc5_ctrl.sv
rtl/rc5_dpath.sv
rtl/rc5_block_cipher.sv
bench/rc5_result_check_pkg.sv
bench/tb_top.sv
